// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/crp_pkg.sv
// Shared types and constants for the RIFF/WAVE chunk parser.
// Used by the controller, the datapath and the top level; depends on nothing.
package crp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [9:0]  MS_PER_S = 10'd1000;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_SIZE_BAD  = 3'd3;
  localparam logic [2:0] ST_NO_DATA   = 3'd4;
  localparam logic [2:0] ST_ZERO_RATE = 3'd5;

  typedef enum logic [3:0] {
    PH_RIFF_TAG, PH_RIFF_LEN, PH_WAVE_TAG, PH_CHUNK_ID, PH_CHUNK_LEN,
    PH_FMT_BODY, PH_DATA_BODY, PH_SKIP_BODY, PH_PAD, PH_IDLE
  } phase_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_ERR, EM_DATA, EM_FIN_DATA, EM_FIN_EMPTY
  } emit_t;

  typedef struct packed {
    logic       shift;     // shift byte into header word, count it
    logic       foff_inc;  // advance file offset
    logic       fbc_clr;   // restart field byte count
    logic       set_feo;   // take RIFF length
    logic       wave_ok;   // clear format fields and file offset
    logic       set_tag;   // take chunk tag
    logic       set_len;   // take chunk length
    logic       body;      // consume a fmt or skipped body byte
    logic       capture;   // body byte belongs to fmt chunk
    logic       data_dec;  // consume a data byte
    logic       pad_clr;   // consume the pad byte
    logic       clear_all; // end of file: back to reset values
    emit_t      emit;
    logic [2:0] err_code;
  } ctl_cmd_t;

  typedef struct packed {
    logic word_done;
    logic is_riff;
    logic is_wave;
    logic len_eq;
    logic len_zero;
    logic tag_data;
    logic tag_fmt;
    logic rem_one;
    logic more_next;
    logic feo_nz;
    logic pad;
  } ctl_sts_t;

endpackage

// File: hdl/riff_wave_chunk_parser.sv
// Top level of the RIFF/WAVE chunk parser: configuration register and stream ports.
// Depends on crp_pkg; instantiates crp_ctrl and crp_dp (which holds crp_div).
//
// The parser takes a WAV file one byte per input beat, with in_tlast on the
// final byte of the file. It checks the RIFF and WAVE tags, walks the chunks,
// captures channels, sample rate, byte rate and sample width from the fmt
// chunk, skips every other chunk (odd lengths carry one pad byte), and passes
// each byte of the data chunk out as one result beat. The data chunk length
// must equal the expected_data_size register (byte address 0), or a size
// mismatch status is sent. The last data byte carries out_tlast together with
// the duration in milliseconds, size times 1000 over the byte rate, saturated
// to 32 bits; a zero byte rate gives status 5 instead. Errors come as status
// beats (out_tuser high) and stop the parse until the next in_tlast, which
// always re-arms the parser; a file that ends early reports status 4. A
// completing byte with a nonzero byte rate, a zero-length data chunk or
// the last data byte, starts a restoring divider that produces one quotient
// bit per cycle; out_tvalid rises only when the divider is done, and no
// byte is taken in between. With a zero byte rate the completion is sent
// at once like any other beat.
// A result waiting in the output register does not block the next byte as
// long as out_tready takes it in the same cycle.
module riff_wave_chunk_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tlast,   // end_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] data_byte, [10:8] status, [42:11] length_ms, [58:43] channels,
  // [90:59] sample_rate, [122:91] avg_bytes_per_sec, [138:123] bits_per_sample,
  // [143:139] zero
  output logic [143:0] out_tdata,
  output logic         out_tlast,  // last
  output logic         out_tuser,  // kind
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [31:0]       exp_size_r;
  logic              fire;
  crp_pkg::ctl_cmd_t cmd;
  crp_pkg::ctl_sts_t sts;
  logic              ready;
  logic [7:0]        o_byte;
  logic [2:0]        o_status;
  logic [31:0]       o_ms;
  logic [15:0]       o_chan;
  logic [31:0]       o_srate;
  logic [31:0]       o_brate;
  logic [15:0]       o_bits;

  // Single register; the upper address bit selects nothing beyond it.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? exp_size_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_size_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == 1'b0)) begin
      exp_size_r <= cfg_pwdata;
    end
  end

  assign in_tready = ready;
  assign fire      = in_tvalid && ready;

  crp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .eof   (in_tlast),
    .sts   (sts),
    .cmd   (cmd)
  );

  crp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .in_byte         (in_tdata),
    .exp_size        (exp_size_r),
    .cmd             (cmd),
    .sts             (sts),
    .in_ready        (ready),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_kind        (out_tuser),
    .out_last        (out_tlast),
    .out_data_byte   (o_byte),
    .out_status      (o_status),
    .out_length_ms   (o_ms),
    .out_channels    (o_chan),
    .out_sample_rate (o_srate),
    .out_byte_rate   (o_brate),
    .out_bits        (o_bits)
  );

  assign out_tdata = {5'd0, o_bits, o_brate, o_srate, o_chan, o_ms, o_status, o_byte};

endmodule

// File: hdl/crp_div.sv
// Restoring divider, one quotient bit per cycle, with 32-bit saturation.
// Uses no package items; instantiated by the datapath.
module crp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [41:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [41:0] num_r;
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] rem2;
  logic        ge;
  logic [32:0] rem_sub;
  logic [41:0] num_nxt;

  assign rem2    = {rem_r, num_r[41]};
  assign ge      = rem2 >= {1'b0, den_r};
  assign rem_sub = ge ? (rem2 - {1'b0, den_r}) : rem2;
  assign num_nxt = {num_r[40:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd42;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_sub[31:0];
    end
  end

  assign busy     = busy_r;
  assign done     = busy_r && (cnt_r == 6'd1);
  assign quotient = (|num_nxt[41:32]) ? 32'hFFFF_FFFF : num_nxt[31:0];

endmodule

// File: hdl/crp_ctrl.sv
// Parse controller: phase state machine that turns each accepted byte into commands.
// Depends on crp_pkg for the phase, emit, command and status types.
module crp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                eof,
  input  crp_pkg::ctl_sts_t   sts,
  output crp_pkg::ctl_cmd_t   cmd
);

  crp_pkg::phase_t ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= crp_pkg::PH_RIFF_TAG;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    crp_pkg::ctl_cmd_t c;
    c        = '0;
    c.emit   = crp_pkg::EM_NONE;
    ph_nxt   = ph_r;
    if (fire) begin
      case (ph_r)
        crp_pkg::PH_RIFF_TAG, crp_pkg::PH_RIFF_LEN, crp_pkg::PH_WAVE_TAG,
        crp_pkg::PH_CHUNK_ID, crp_pkg::PH_CHUNK_LEN: begin
          c.shift    = 1'b1;
          c.foff_inc = (ph_r == crp_pkg::PH_CHUNK_ID) || (ph_r == crp_pkg::PH_CHUNK_LEN);
          if (sts.word_done) begin
            c.fbc_clr = 1'b1;
            case (ph_r)
              crp_pkg::PH_RIFF_TAG: begin
                if (!sts.is_riff) begin
                  c.emit = crp_pkg::EM_ERR; c.err_code = crp_pkg::ST_NOT_RIFF;
                  ph_nxt = crp_pkg::PH_IDLE;
                end else begin
                  ph_nxt = crp_pkg::PH_RIFF_LEN;
                end
              end
              crp_pkg::PH_RIFF_LEN: begin
                c.set_feo = 1'b1;
                ph_nxt    = crp_pkg::PH_WAVE_TAG;
              end
              crp_pkg::PH_WAVE_TAG: begin
                if (!sts.is_wave) begin
                  c.emit = crp_pkg::EM_ERR; c.err_code = crp_pkg::ST_NOT_WAVE;
                  ph_nxt = crp_pkg::PH_IDLE;
                end else begin
                  c.wave_ok = 1'b1;
                  if (sts.feo_nz) begin
                    ph_nxt = crp_pkg::PH_CHUNK_ID;
                  end else begin
                    c.emit = crp_pkg::EM_ERR; c.err_code = crp_pkg::ST_NO_DATA;
                    ph_nxt = crp_pkg::PH_IDLE;
                  end
                end
              end
              crp_pkg::PH_CHUNK_ID: begin
                c.set_tag = 1'b1;
                ph_nxt    = crp_pkg::PH_CHUNK_LEN;
              end
              default: begin
                c.set_len = 1'b1;
                if (sts.tag_data) begin
                  if (!sts.len_eq) begin
                    c.emit = crp_pkg::EM_ERR; c.err_code = crp_pkg::ST_SIZE_BAD;
                    ph_nxt = crp_pkg::PH_IDLE;
                  end else if (sts.len_zero) begin
                    c.emit = crp_pkg::EM_FIN_EMPTY;
                    ph_nxt = crp_pkg::PH_IDLE;
                  end else begin
                    ph_nxt = crp_pkg::PH_DATA_BODY;
                  end
                end else if (sts.len_zero) begin
                  if (sts.more_next) begin
                    ph_nxt = crp_pkg::PH_CHUNK_ID;
                  end else begin
                    c.emit = crp_pkg::EM_ERR; c.err_code = crp_pkg::ST_NO_DATA;
                    ph_nxt = crp_pkg::PH_IDLE;
                  end
                end else begin
                  ph_nxt = sts.tag_fmt ? crp_pkg::PH_FMT_BODY : crp_pkg::PH_SKIP_BODY;
                end
              end
            endcase
          end
        end
        crp_pkg::PH_FMT_BODY, crp_pkg::PH_SKIP_BODY: begin
          c.body    = 1'b1;
          c.capture = (ph_r == crp_pkg::PH_FMT_BODY);
          if (sts.rem_one) begin
            if (sts.pad) begin
              ph_nxt = crp_pkg::PH_PAD;
            end else if (sts.more_next) begin
              c.fbc_clr = 1'b1;
              ph_nxt    = crp_pkg::PH_CHUNK_ID;
            end else begin
              c.emit = crp_pkg::EM_ERR; c.err_code = crp_pkg::ST_NO_DATA;
              ph_nxt = crp_pkg::PH_IDLE;
            end
          end
        end
        crp_pkg::PH_DATA_BODY: begin
          c.data_dec = 1'b1;
          if (sts.rem_one) begin
            c.emit = crp_pkg::EM_FIN_DATA;
            ph_nxt = crp_pkg::PH_IDLE;
          end else begin
            c.emit = crp_pkg::EM_DATA;
          end
        end
        crp_pkg::PH_PAD: begin
          c.pad_clr = 1'b1;
          if (sts.more_next) begin
            c.fbc_clr = 1'b1;
            ph_nxt    = crp_pkg::PH_CHUNK_ID;
          end else begin
            c.emit = crp_pkg::EM_ERR; c.err_code = crp_pkg::ST_NO_DATA;
            ph_nxt = crp_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (eof) begin
        // A file that ends before the parse settles reports missing data instead.
        if ((ph_r != crp_pkg::PH_IDLE) && (ph_nxt != crp_pkg::PH_IDLE)) begin
          c.emit     = crp_pkg::EM_ERR;
          c.err_code = crp_pkg::ST_NO_DATA;
        end
        c.clear_all = 1'b1;
        ph_nxt      = crp_pkg::PH_RIFF_TAG;
      end
    end
    cmd = c;
  end

endmodule

// File: hdl/crp_dp.sv
// Parse datapath: header word, offsets, chunk counters, format fields and result register.
// Depends on crp_pkg and instantiates the crp_div divider for the duration.
module crp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          in_byte,
  input  logic [31:0]         exp_size,
  input  crp_pkg::ctl_cmd_t   cmd,
  output crp_pkg::ctl_sts_t   sts,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_kind,
  output logic                out_last,
  output logic [7:0]          out_data_byte,
  output logic [2:0]          out_status,
  output logic [31:0]         out_length_ms,
  output logic [15:0]         out_channels,
  output logic [31:0]         out_sample_rate,
  output logic [31:0]         out_byte_rate,
  output logic [15:0]         out_bits
);

  logic [4:0]  fbc_r;
  logic [31:0] ws_r;
  logic        tag_data_r;
  logic        tag_fmt_r;
  logic [31:0] rem_r;
  logic [31:0] feo_r;
  logic [31:0] foff_r;
  logic        pad_r;
  logic [15:0] chan_r;
  logic [31:0] srate_r;
  logic [31:0] brate_r;
  logic [15:0] bits_r;
  logic        ov_r;
  logic        kind_r;
  logic        last_r;
  logic [7:0]  byte_r;
  logic [2:0]  stat_r;
  logic [31:0] ms_r;
  logic [15:0] ochan_r;
  logic [31:0] osrate_r;
  logic [31:0] obrate_r;
  logic [15:0] obits_r;

  logic [31:0] w_next;
  logic [31:0] foff_inc1;
  logic        fin;
  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_q;
  logic [41:0] product;
  logic [1:0]  fmt_lane;

  assign w_next    = {in_byte, ws_r[31:8]};
  assign foff_inc1 = foff_r + 32'd1;
  assign fin       = (cmd.emit == crp_pkg::EM_FIN_DATA) || (cmd.emit == crp_pkg::EM_FIN_EMPTY);
  assign div_start = fire && fin && (brate_r != 32'd0);
  assign product   = {10'd0, exp_size} * {32'd0, crp_pkg::MS_PER_S};
  assign fmt_lane  = fbc_r[1:0];

  always_comb begin
    sts           = '0;
    sts.word_done = (fbc_r == 5'd3);
    sts.is_riff   = (w_next == crp_pkg::TAG_RIFF);
    sts.is_wave   = (w_next == crp_pkg::TAG_WAVE);
    sts.len_eq    = (w_next == exp_size);
    sts.len_zero  = (w_next == 32'd0);
    sts.tag_data  = tag_data_r;
    sts.tag_fmt   = tag_fmt_r;
    sts.rem_one   = (rem_r == 32'd1);
    sts.more_next = (foff_inc1 < feo_r);
    sts.feo_nz    = (feo_r != 32'd0);
    sts.pad       = pad_r;
  end

  assign in_ready = !div_busy && (!ov_r || out_ready);

  crp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (brate_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Parse state.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && cmd.clear_all)) begin
      fbc_r      <= '0;
      ws_r       <= '0;
      tag_data_r <= 1'b0;
      tag_fmt_r  <= 1'b0;
      rem_r      <= '0;
      feo_r      <= '0;
      foff_r     <= '0;
      pad_r      <= 1'b0;
      chan_r     <= '0;
      srate_r    <= '0;
      brate_r    <= '0;
      bits_r     <= '0;
    end else if (fire) begin
      if (cmd.fbc_clr) begin
        fbc_r <= '0;
      end else if ((cmd.shift || cmd.body) && (fbc_r != 5'd16)) begin
        fbc_r <= fbc_r + 5'd1;
      end
      if (cmd.shift) begin
        ws_r <= w_next;
      end
      if (cmd.wave_ok) begin
        foff_r  <= '0;
        chan_r  <= '0;
        srate_r <= '0;
        brate_r <= '0;
        bits_r  <= '0;
      end else if (cmd.foff_inc || cmd.body || cmd.pad_clr) begin
        foff_r <= foff_inc1;
      end
      if (cmd.set_feo) begin
        feo_r <= w_next - 32'd4;
      end
      if (cmd.set_tag) begin
        tag_data_r <= (w_next == crp_pkg::TAG_DATA);
        tag_fmt_r  <= (w_next == crp_pkg::TAG_FMT);
      end
      if (cmd.set_len) begin
        rem_r <= w_next;
        pad_r <= w_next[0];
      end else if (cmd.body || cmd.data_dec) begin
        rem_r <= rem_r - 32'd1;
      end
      if (cmd.pad_clr) begin
        pad_r <= 1'b0;
      end
      if (cmd.body && cmd.capture && !fbc_r[4]) begin
        case (fbc_r[3:0])
          4'd2: chan_r[7:0]   <= in_byte;
          4'd3: chan_r[15:8]  <= in_byte;
          4'd4, 4'd5, 4'd6, 4'd7: srate_r[fmt_lane*8 +: 8] <= in_byte;
          4'd8, 4'd9, 4'd10, 4'd11: brate_r[fmt_lane*8 +: 8] <= in_byte;
          4'd14: bits_r[7:0]  <= in_byte;
          4'd15: bits_r[15:8] <= in_byte;
          default: begin
          end
        endcase
      end
    end
  end

  // Result register; a completion with a nonzero byte rate waits for the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (fire && (cmd.emit != crp_pkg::EM_NONE)) begin
      ov_r <= !div_start;
    end else if (div_done) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (cmd.emit != crp_pkg::EM_NONE)) begin
      kind_r   <= (cmd.emit == crp_pkg::EM_ERR) || (cmd.emit == crp_pkg::EM_FIN_EMPTY);
      last_r   <= fin;
      byte_r   <= ((cmd.emit == crp_pkg::EM_DATA) || (cmd.emit == crp_pkg::EM_FIN_DATA))
                  ? in_byte : 8'd0;
      stat_r   <= (cmd.emit == crp_pkg::EM_ERR) ? cmd.err_code :
                  (fin && (brate_r == 32'd0)) ? crp_pkg::ST_ZERO_RATE : crp_pkg::ST_OK;
      ms_r     <= '0;
      ochan_r  <= (cmd.emit == crp_pkg::EM_ERR) ? 16'd0 : chan_r;
      osrate_r <= (cmd.emit == crp_pkg::EM_ERR) ? 32'd0 : srate_r;
      obrate_r <= (cmd.emit == crp_pkg::EM_ERR) ? 32'd0 : brate_r;
      obits_r  <= (cmd.emit == crp_pkg::EM_ERR) ? 16'd0 : bits_r;
    end else if (div_done) begin
      ms_r <= div_q;
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = kind_r;
  assign out_last        = last_r;
  assign out_data_byte   = byte_r;
  assign out_status      = stat_r;
  assign out_length_ms   = ms_r;
  assign out_channels    = ochan_r;
  assign out_sample_rate = osrate_r;
  assign out_byte_rate   = obrate_r;
  assign out_bits        = obits_r;

endmodule

// File: hdl/crp_chk.sv
// Port-level checker for the RIFF/WAVE chunk parser, bound to the top level.
// Depends on assert_macros.svh and crp_pkg for the status codes.
`include "assert_macros.svh"

module crp_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tlast,
  input logic         out_tuser,
  input logic         cfg_pready
);

  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `AST_IMPL(a_err_clean, out_tvalid && out_tuser && !out_tlast, (out_tdata[10:8] != crp_pkg::ST_OK) && (out_tdata[7:0] == 8'd0) && (out_tdata[143:11] == 133'd0))
  `AST_IMPL(a_data_ok, out_tvalid && !out_tuser && !out_tlast, out_tdata[10:8] == crp_pkg::ST_OK)
  `AST_IMPL(a_mid_no_ms, out_tvalid && !out_tlast, out_tdata[42:11] == 32'd0)
  `AST_IMPL(a_apb_ready, 1'b1, cfg_pready)

endmodule

bind riff_wave_chunk_parser crp_chk u_crp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);
